[sv/tgc_pkg.sv]
// ---------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants of the touch gesture classifier.
// ---------------------------------------------------------------------------
package tgc_pkg;

   localparam int unsigned SLOTS_DEFAULT = 16;

   localparam logic [2:0] REQ_DOWN   = 3'd0;
   localparam logic [2:0] REQ_MOVE   = 3'd1;
   localparam logic [2:0] REQ_UP     = 3'd2;
   localparam logic [2:0] REQ_CANCEL = 3'd3;
   localparam logic [2:0] REQ_TICK   = 3'd4;

   localparam logic [2:0] KIND_FREE    = 3'd0;
   localparam logic [2:0] KIND_UNCLEAR = 3'd1;
   localparam logic [2:0] KIND_TAP     = 3'd2;
   localparam logic [2:0] KIND_MOTION  = 3'd3;
   localparam logic [2:0] KIND_DOUBLE  = 3'd4;

   localparam logic [2:0] EV_TAP_DOWN   = 3'd0;
   localparam logic [2:0] EV_TAP_UP     = 3'd1;
   localparam logic [2:0] EV_DRAG       = 3'd2;
   localparam logic [2:0] EV_MOTION     = 3'd3;
   localparam logic [2:0] EV_MOTION_END = 3'd4;
   localparam logic [2:0] EV_DOUBLE     = 3'd5;
   localparam logic [2:0] EV_DROP       = 3'd6;

   localparam logic [1:0] CSR_TAP_TIME  = 2'd0;
   localparam logic [1:0] CSR_DTAP_GAP  = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED = 2'd2;
   localparam logic [1:0] CSR_IDLE_MOT  = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] touch_id;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [15:0] time_delta;
   } req_type_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [15:0] event_id;
      logic [11:0] from_x;
      logic [11:0] from_y;
      logic [11:0] to_x;
      logic [11:0] to_y;
      logic        last_result;
   } rsp_type_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [11:0] x;
      logic [11:0] y;
      logic [15:0] elapsed;
   } slot_type;

endpackage

[sv/tgc_slot_mem.sv]
// ---------------------------------------------------------------------------
// tgc_slot_mem
// Slot table: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tgc_slot_mem
   import tgc_pkg::*;
#(
   parameter int unsigned SLOTS = SLOTS_DEFAULT,
   localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [AW-1:0]  wr_addr,
   input  slot_type       wr_data,
   input  logic [AW-1:0]  rd_addr,
   output slot_type       rd_data
);

   slot_type mem_ff [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[sv/touch_gesture_classifier.sv]
// ---------------------------------------------------------------------------
// touch_gesture_classifier
// Touch slot table with gesture classification and event output.
// ---------------------------------------------------------------------------
// Each down, move, up, cancel or tick walks the slot table through a memory with
// a registered read port, one slot per cycle but for a pause at a stale double tap.
//
// Busy:
//   - Down, move, up and cancel keep busy high through a search of every
//     slot and an act state that writes the slot back.
//   - A tick keeps busy high through its walk and a flush state, plus a pair
//     state for every stale double tap, since that slot gives two events.
//   - Request codes 5 to 7 are accepted, leave busy low and give no
//     result.
//
// Events leave on rsp_valid for exactly one cycle each. The receiver cannot
// stall them. The final event of a command is marked by last_result.
// A tick holds each event back until the next one is found or the walk ends,
// so the last one can be marked. The final result of any command is on the
// ports in the first cycle with busy low.
//
// Configuration writes are taken only while the block is idle.
//
// After reset the block runs a clearing pass that marks every slot free, and
// busy is high meanwhile.
module touch_gesture_classifier
   import tgc_pkg::*;
#(
   parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);
   localparam logic [CW-1:0] CNT_END   = CW'(SLOTS);
   localparam logic [CW-1:0] CNT_LAST  = CW'(SLOTS - 1);
   localparam logic [AW-1:0] ADDR_LAST = AW'(SLOTS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_ACT, ST_WALK, ST_PAIR, ST_FLUSH
   } state_type;

   function automatic rsp_type_type mk(input logic [2:0] k, input logic [15:0] id,
                                        input logic [11:0] fx, input logic [11:0] fy,
                                        input logic [11:0] tx, input logic [11:0] ty,
                                        input logic l);
      rsp_type_type r;
      r = '{k, id, fx, fy, tx, ty, l};
      return r;
   endfunction

   state_type     state_ff;
   req_type_type  req_ff;
   logic [CW-1:0] cnt_ff;        // read address counter
   logic          rvalid_ff;     // read data valid this cycle
   logic [AW-1:0] raddr_ff;      // address of the data on rd_data
   logic          found_ff;
   logic [AW-1:0] hit_ff;
   slot_type      hit_slot_ff;   // contents of the matching slot
   logic [24:0]   d2_ff;         // squared distance of the move to the hit slot
   logic [31:0]   ve_ff;         // speed limit times elapsed of the hit slot
   logic          freef_ff;
   logic [AW-1:0] free_ff;
   logic [15:0]   tap_ff, gap_ff, spd_ff, idle_ff;
   logic          held_ff;       // a tick event waits to learn if it is last
   rsp_type_type  held_rsp_ff;
   rsp_type_type  pair_rsp_ff;   // tap up of a stale double tap
   logic          rsp_valid_ff;
   rsp_type_type  rsp_ff;

   logic          mem_we;
   logic [AW-1:0] mem_wa;
   slot_type      mem_wd;
   logic [AW-1:0] rd_addr;
   slot_type      rd_data;

   tgc_slot_mem #(.SLOTS(SLOTS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rd_addr   = cnt_ff[AW-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // First half of the speed test on the read data; registered on a hit.
   logic [11:0] dx, dy;
   logic [23:0] dx2, dy2;
   logic [24:0] d2;
   logic [31:0] ve;
   always_comb begin
      dx  = (req_ff.pos_x > rd_data.x) ? req_ff.pos_x - rd_data.x : rd_data.x - req_ff.pos_x;
      dy  = (req_ff.pos_y > rd_data.y) ? req_ff.pos_y - rd_data.y : rd_data.y - req_ff.pos_y;
      dx2 = 24'(dx) * 24'(dx);
      dy2 = 24'(dy) * 24'(dy);
      d2  = 25'(dx2) + 25'(dy2);
      ve  = 32'(spd_ff) * 32'(rd_data.elapsed);
   end

   // Second half in the act cycle: squared distance times 1e6 against ve squared.
   logic [63:0] lhs, rhs;
   assign lhs = 64'(d2_ff) * 64'd1000000;
   assign rhs = 64'(ve_ff) * 64'(ve_ff);

   // Saturating elapsed time for the tick walk.
   logic [16:0] esum;
   logic [15:0] esat;
   assign esum = 17'(rd_data.elapsed) + 17'(req_ff.time_delta);
   assign esat = esum[16] ? 16'hFFFF : esum[15:0];

   // Per-slot tick decision and write back, done while walking.
   logic          tk_wr, tk_ev, tk_two;
   slot_type      tk_slot;
   rsp_type_type  tk_rsp;
   always_comb begin
      tk_wr   = 1'b0;
      tk_ev   = 1'b0;
      tk_two  = 1'b0;
      tk_slot = rd_data;
      tk_slot.elapsed = esat;
      tk_rsp  = mk(EV_TAP_DOWN, rd_data.id, rd_data.x, rd_data.y, rd_data.x, rd_data.y,
                   1'b0);
      if (rd_data.kind != KIND_FREE) begin
         tk_wr = 1'b1;
         case (rd_data.kind)
            KIND_UNCLEAR: begin
               if (esat >= tap_ff) begin
                  tk_slot.kind = KIND_TAP;
                  tk_ev = 1'b1;
               end
            end
            KIND_DOUBLE: begin
               if (esat > gap_ff) begin
                  tk_slot.kind = KIND_FREE;
                  tk_ev  = 1'b1;
                  tk_two = 1'b1;
               end
            end
            KIND_MOTION: begin
               if (esat > idle_ff) begin
                  tk_ev = 1'b1;
                  tk_rsp.event_kind = EV_MOTION;
               end
            end
            default: ;
         endcase
      end
   end

   // Tap up that follows the tap down of a stale double tap, and the held
   // event marked as the final one of the tick.
   rsp_type_type tk_up, flush_rsp;
   always_comb begin
      tk_up = tk_rsp;
      tk_up.event_kind = EV_TAP_UP;
      flush_rsp = held_rsp_ff;
      flush_rsp.last_result = 1'b1;
   end

   // Act cycle: decide on the matching slot captured during the search.
   logic [2:0]    kind_h;
   slot_type      act_slot;
   logic          act_wr;
   logic          act_ev;
   rsp_type_type  act_rsp;
   logic [AW-1:0] act_addr;
   assign kind_h = hit_slot_ff.kind;
   always_comb begin
      act_slot = hit_slot_ff;
      act_wr   = 1'b0;
      act_ev   = 1'b0;
      act_addr = hit_ff;
      act_rsp  = mk(EV_DROP, req_ff.touch_id, req_ff.pos_x, req_ff.pos_y,
                    req_ff.pos_x, req_ff.pos_y, 1'b1);
      case (req_ff.req_type)
         REQ_DOWN: begin
            if (found_ff) begin
               if (kind_h == KIND_DOUBLE) begin
                  act_ev = 1'b1;
                  act_rsp = mk(EV_DOUBLE, req_ff.touch_id, hit_slot_ff.x, hit_slot_ff.y,
                               hit_slot_ff.x, hit_slot_ff.y, 1'b1);
                  act_wr = 1'b1;
                  act_slot.kind = KIND_FREE;
               end
            end else if (freef_ff) begin
               act_wr   = 1'b1;
               act_addr = free_ff;
               act_slot = '{KIND_UNCLEAR, req_ff.touch_id, req_ff.pos_x, req_ff.pos_y,
                            16'd0};
            end else begin
               act_ev = 1'b1;
            end
         end
         REQ_MOVE: begin
            if (found_ff) begin
               act_wr = 1'b1;
               if (kind_h == KIND_UNCLEAR && lhs > rhs) act_slot.kind = KIND_MOTION;
               if (act_slot.kind == KIND_MOTION) begin
                  act_ev = 1'b1;
                  act_rsp = mk(EV_MOTION, req_ff.touch_id, hit_slot_ff.x, hit_slot_ff.y,
                               req_ff.pos_x, req_ff.pos_y, 1'b1);
               end else if (kind_h == KIND_TAP) begin
                  act_ev = 1'b1;
                  act_rsp = mk(EV_DRAG, req_ff.touch_id, req_ff.pos_x, req_ff.pos_y,
                               req_ff.pos_x, req_ff.pos_y, 1'b1);
               end
               act_slot.elapsed = '0;
               act_slot.x = req_ff.pos_x;
               act_slot.y = req_ff.pos_y;
            end
         end
         default: begin
            if (found_ff) begin
               act_wr = 1'b1;
               act_rsp = mk(EV_TAP_UP, req_ff.touch_id, hit_slot_ff.x, hit_slot_ff.y,
                            hit_slot_ff.x, hit_slot_ff.y, 1'b1);
               if (kind_h == KIND_UNCLEAR && req_ff.req_type == REQ_UP) begin
                  act_slot.kind = KIND_DOUBLE;
                  act_slot.elapsed = '0;
               end else begin
                  act_slot.kind = KIND_FREE;
                  if (kind_h == KIND_TAP) act_ev = 1'b1;
                  if (kind_h == KIND_MOTION) begin
                     act_ev = 1'b1;
                     act_rsp.event_kind = EV_MOTION_END;
                  end
               end
            end
         end
      endcase
   end

   // Single write port: clearing pass, act write back or tick write back.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = raddr_ff;
      mem_wd = tk_slot;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff[AW-1:0];
            mem_wd = '0;
         end
         ST_ACT: begin
            mem_we = act_wr;
            mem_wa = act_addr;
            mem_wd = act_slot;
         end
         ST_WALK: begin
            mem_we = rvalid_ff && tk_wr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ff       <= '0;
         cnt_ff       <= '0;
         rvalid_ff    <= 1'b0;
         raddr_ff     <= '0;
         found_ff     <= 1'b0;
         hit_ff       <= '0;
         hit_slot_ff  <= '0;
         d2_ff        <= '0;
         ve_ff        <= '0;
         freef_ff     <= 1'b0;
         free_ff      <= '0;
         tap_ff       <= 16'd200;
         gap_ff       <= 16'd200;
         spd_ff       <= 16'd50;
         idle_ff      <= 16'd50;
         held_ff      <= 1'b0;
         held_rsp_ff  <= '0;
         pair_rsp_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TAP_TIME:  tap_ff  <= csr_data;
               CSR_DTAP_GAP:  gap_ff  <= csr_data;
               CSR_MAX_SPEED: spd_ff  <= csr_data;
               CSR_IDLE_MOT:  idle_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_CLEAR: begin
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= ST_IDLE;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            ST_IDLE: begin
               cnt_ff   <= '0;
               found_ff <= 1'b0;
               freef_ff <= 1'b0;
               held_ff  <= 1'b0;
               if (start) begin
                  req_ff <= req_data;
                  if (req_data.req_type == REQ_TICK) begin
                     state_ff <= ST_WALK;
                  end else if (req_data.req_type inside
                               {REQ_DOWN, REQ_MOVE, REQ_UP, REQ_CANCEL}) begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               // issue reads for every slot, consume each in the cycle after
               if (cnt_ff != CNT_END) begin
                  rvalid_ff <= 1'b1;
                  raddr_ff  <= cnt_ff[AW-1:0];
                  cnt_ff    <= cnt_ff + CW'(1);
               end
               if (rvalid_ff) begin
                  if (rd_data.kind != KIND_FREE && rd_data.id == req_ff.touch_id
                      && !found_ff) begin
                     found_ff    <= 1'b1;
                     hit_ff      <= raddr_ff;
                     hit_slot_ff <= rd_data;
                     d2_ff       <= d2;
                     ve_ff       <= ve;
                  end
                  if (rd_data.kind == KIND_FREE && !freef_ff) begin
                     freef_ff <= 1'b1;
                     free_ff  <= raddr_ff;
                  end
                  if (raddr_ff == ADDR_LAST) state_ff <= ST_ACT;
               end
            end
            ST_ACT: begin
               state_ff <= ST_IDLE;
               if (act_ev) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= act_rsp;
               end
            end
            ST_WALK: begin
               // hold the read counter while a stale double tap needs the pair state
               if (cnt_ff != CNT_END && !(rvalid_ff && tk_two)) begin
                  rvalid_ff <= 1'b1;
                  raddr_ff  <= cnt_ff[AW-1:0];
                  cnt_ff    <= cnt_ff + CW'(1);
               end
               if (rvalid_ff) begin
                  if (tk_ev) begin
                     if (held_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= held_rsp_ff;
                     end
                     held_ff     <= 1'b1;
                     held_rsp_ff <= tk_rsp;
                  end
                  if (tk_two) begin
                     pair_rsp_ff <= tk_up;
                     state_ff    <= ST_PAIR;
                  end else if (raddr_ff == ADDR_LAST) begin
                     state_ff <= ST_FLUSH;
                  end
               end
            end
            ST_PAIR: begin
               // send the held tap down, hold the tap up in its place
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= held_rsp_ff;
               held_rsp_ff  <= pair_rsp_ff;
               if (cnt_ff != CNT_END) begin
                  rvalid_ff <= 1'b1;
                  raddr_ff  <= cnt_ff[AW-1:0];
                  cnt_ff    <= cnt_ff + CW'(1);
                  state_ff  <= ST_WALK;
               end else begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_FLUSH: begin
               // drop the held event out as the final one of the tick
               state_ff <= ST_IDLE;
               if (held_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= flush_rsp;
                  held_ff      <= 1'b0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data));
   a_pair_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAIR) |-> held_ff);
   a_act_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |=> (state_ff == ST_IDLE));
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy);
   a_wa_known: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !$isunknown(mem_wa));

endmodule

[tb/sv/tb_touch_gesture_classifier.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_touch_gesture_classifier
// Self-checking bench: drives touch down/move/up/cancel/tick commands,
// predicts the gesture events from its own slot table model and compares
// every event strobe against the oldest predicted event.
// ---------------------------------------------------------------------------
module tb_touch_gesture_classifier;
   import tgc_pkg::*;

   localparam int NSLOT      = 16;
   localparam int SETTLE     = 2 * NSLOT + 8;   // longest request plus margin
   localparam int CYCLE_CAP  = 400000;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_type_type req_data;
   logic         rsp_valid;
   rsp_type_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;

   touch_gesture_classifier #(.SLOTS(NSLOT)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Predictor state: gesture timing registers and the slot table.
   logic [15:0]  tap_ms, gap_ms, speed_lim, idle_ms;
   logic [2:0]   tbl_kind[NSLOT];
   logic [15:0]  tbl_id[NSLOT];
   logic [11:0]  tbl_x[NSLOT];
   logic [11:0]  tbl_y[NSLOT];
   logic [15:0]  tbl_ms[NSLOT];

   rsp_type_type pending_events[$];
   int           errors     = 0;
   int           items_sent = 0;
   int           events_seen = 0;
   int           sender_idle_pct = 0;
   int           cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_CAP);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Compare each event strobe against the oldest predicted event.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         events_seen++;
         if (pending_events.size() == 0) begin
            errors++;
            $display("%0t: unexpected event, expected none, actual %p", $time, rsp_data);
         end else begin
            rsp_type_type want;
            want = pending_events.pop_front();
            if (rsp_data !== want) begin
               errors++;
               $display("%0t: event mismatch, expected %p, actual %p",
                        $time, want, rsp_data);
            end
         end
      end
   end

   function automatic rsp_type_type make_event(logic [2:0] kind, logic [15:0] id,
         logic [11:0] fx, logic [11:0] fy, logic [11:0] tx, logic [11:0] ty);
      rsp_type_type ev;
      ev.event_kind  = kind;
      ev.event_id    = id;
      ev.from_x      = fx;
      ev.from_y      = fy;
      ev.to_x        = tx;
      ev.to_y        = ty;
      ev.last_result = 1'b0;
      return ev;
   endfunction

   function automatic int lowest_slot_with(logic [15:0] id);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_kind[i] != KIND_FREE && tbl_id[i] == id) return i;
      return -1;
   endfunction

   // Advance the slot table by one accepted command; queue the events it causes.
   task automatic predict_gestures(req_type_type r);
      rsp_type_type evs[$];
      int s;
      int f;
      logic [16:0] sum;
      longint unsigned dx, dy, dsq, lim;
      s = -1;
      f = -1;
      if (r.req_type == REQ_TICK) begin
         for (int i = 0; i < NSLOT; i++) begin
            if (tbl_kind[i] == KIND_FREE) continue;
            sum = tbl_ms[i] + r.time_delta;
            tbl_ms[i] = sum[16] ? 16'hFFFF : sum[15:0];
            if (tbl_kind[i] == KIND_UNCLEAR) begin
               if (tbl_ms[i] >= tap_ms) begin
                  tbl_kind[i] = KIND_TAP;
                  evs.push_back(make_event(EV_TAP_DOWN, tbl_id[i], tbl_x[i], tbl_y[i],
                                           tbl_x[i], tbl_y[i]));
               end
            end else if (tbl_kind[i] == KIND_DOUBLE) begin
               if (tbl_ms[i] > gap_ms) begin
                  tbl_kind[i] = KIND_FREE;
                  evs.push_back(make_event(EV_TAP_DOWN, tbl_id[i], tbl_x[i], tbl_y[i],
                                           tbl_x[i], tbl_y[i]));
                  evs.push_back(make_event(EV_TAP_UP, tbl_id[i], tbl_x[i], tbl_y[i],
                                           tbl_x[i], tbl_y[i]));
               end
            end else if (tbl_kind[i] == KIND_MOTION) begin
               if (tbl_ms[i] > idle_ms)
                  evs.push_back(make_event(EV_MOTION, tbl_id[i], tbl_x[i], tbl_y[i],
                                           tbl_x[i], tbl_y[i]));
            end
         end
      end else if (r.req_type == REQ_DOWN) begin
         s = lowest_slot_with(r.touch_id);
         if (s >= 0) begin
            if (tbl_kind[s] == KIND_DOUBLE) begin
               evs.push_back(make_event(EV_DOUBLE, r.touch_id, tbl_x[s], tbl_y[s],
                                        tbl_x[s], tbl_y[s]));
               tbl_kind[s] = KIND_FREE;
            end
         end else begin
            for (int i = NSLOT - 1; i >= 0; i--)
               if (tbl_kind[i] == KIND_FREE) f = i;
            if (f >= 0) begin
               tbl_kind[f] = KIND_UNCLEAR;
               tbl_id[f]   = r.touch_id;
               tbl_x[f]    = r.pos_x;
               tbl_y[f]    = r.pos_y;
               tbl_ms[f]   = '0;
            end else begin
               evs.push_back(make_event(EV_DROP, r.touch_id, r.pos_x, r.pos_y,
                                        r.pos_x, r.pos_y));
            end
         end
      end else if (r.req_type == REQ_MOVE) begin
         s = lowest_slot_with(r.touch_id);
         if (s >= 0) begin
            dx   = (r.pos_x > tbl_x[s]) ? r.pos_x - tbl_x[s] : tbl_x[s] - r.pos_x;
            dy   = (r.pos_y > tbl_y[s]) ? r.pos_y - tbl_y[s] : tbl_y[s] - r.pos_y;
            dsq  = (dx * dx + dy * dy) * 64'd1000000;
            lim  = longint'(speed_lim) * longint'(tbl_ms[s]);
            if (tbl_kind[s] == KIND_UNCLEAR && dsq > lim * lim)
               tbl_kind[s] = KIND_MOTION;
            if (tbl_kind[s] == KIND_MOTION)
               evs.push_back(make_event(EV_MOTION, r.touch_id, tbl_x[s], tbl_y[s],
                                        r.pos_x, r.pos_y));
            else if (tbl_kind[s] == KIND_TAP)
               evs.push_back(make_event(EV_DRAG, r.touch_id, r.pos_x, r.pos_y,
                                        r.pos_x, r.pos_y));
            tbl_ms[s] = '0;
            tbl_x[s]  = r.pos_x;
            tbl_y[s]  = r.pos_y;
         end
      end else if (r.req_type == REQ_UP || r.req_type == REQ_CANCEL) begin
         s = lowest_slot_with(r.touch_id);
         if (s >= 0) begin
            if (tbl_kind[s] == KIND_UNCLEAR) begin
               if (r.req_type == REQ_UP) begin
                  tbl_kind[s] = KIND_DOUBLE;
                  tbl_ms[s]   = '0;
               end else begin
                  tbl_kind[s] = KIND_FREE;
               end
            end else begin
               if (tbl_kind[s] == KIND_TAP)
                  evs.push_back(make_event(EV_TAP_UP, r.touch_id, tbl_x[s], tbl_y[s],
                                           tbl_x[s], tbl_y[s]));
               else if (tbl_kind[s] == KIND_MOTION)
                  evs.push_back(make_event(EV_MOTION_END, r.touch_id, tbl_x[s],
                                           tbl_y[s], tbl_x[s], tbl_y[s]));
               tbl_kind[s] = KIND_FREE;
            end
         end
      end
      // Codes above tick fall through with no effect.
      if (evs.size() > 0) evs[evs.size() - 1].last_result = 1'b1;
      foreach (evs[i]) pending_events.push_back(evs[i]);
   endtask

   // Present one command at the falling edge and hold it until the block takes it.
   task automatic send_cmd(logic [2:0] kind, logic [15:0] id, logic [11:0] x,
                           logic [11:0] y, logic [15:0] dt);
      req_type_type r;
      r.req_type   = kind;
      r.touch_id   = id;
      r.pos_x      = x;
      r.pos_y      = y;
      r.time_delta = dt;
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      @(negedge clock);
      start    = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predict_gestures(r);
      items_sent++;
      @(negedge clock);
      start = 1'b0;
   endtask

   // Hold off until every predicted event has arrived and the block is quiet.
   task automatic drain_events();
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_TAP_TIME:  tap_ms    = val;
         CSR_DTAP_GAP:  gap_ms    = val;
         CSR_MAX_SPEED: speed_lim = val;
         default:       idle_ms   = val;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_timing(logic [15:0] tap, logic [15:0] gap, logic [15:0] spd,
                             logic [15:0] idle);
      drain_events();
      write_csr(CSR_TAP_TIME, tap);
      write_csr(CSR_DTAP_GAP, gap);
      write_csr(CSR_MAX_SPEED, spd);
      write_csr(CSR_IDLE_MOT, idle);
   endtask

   // Tap, drag, motion, double tap and stale double tap, all under reset timing.
   task automatic test_gesture_paths();
      send_cmd(REQ_DOWN, 16'h0000, 12'd0, 12'd0, 16'h0);
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'd200);          // becomes tap
      send_cmd(REQ_MOVE, 16'h0000, 12'hFFF, 12'hFFF, 16'h0);     // drag
      send_cmd(REQ_UP, 16'h0000, 12'd0, 12'd0, 16'h0);
      send_cmd(REQ_DOWN, 16'hFFFF, 12'd100, 12'd100, 16'hFFFF);
      send_cmd(REQ_MOVE, 16'hFFFF, 12'd101, 12'd100, 16'h0);     // zero elapsed -> motion
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'd51);           // stationary motion
      send_cmd(REQ_UP, 16'hFFFF, 12'd0, 12'd0, 16'h0);           // motion ended
      send_cmd(REQ_DOWN, 16'd5, 12'd10, 12'd10, 16'h0);
      send_cmd(REQ_UP, 16'd5, 12'd0, 12'd0, 16'h0);              // wait for second down
      send_cmd(REQ_MOVE, 16'd5, 12'd11, 12'd11, 16'h0);          // silent update
      send_cmd(REQ_DOWN, 16'd5, 12'd11, 12'd11, 16'h0);          // double tap
      send_cmd(REQ_DOWN, 16'd6, 12'd20, 12'd30, 16'h0);
      send_cmd(REQ_UP, 16'd6, 12'd0, 12'd0, 16'h0);
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'd201);          // stale: tap down + up
      send_cmd(REQ_DOWN, 16'd7, 12'd1, 12'd2, 16'h0);
      send_cmd(REQ_DOWN, 16'd7, 12'd9, 12'd9, 16'h0);            // busy id, ignored
      send_cmd(REQ_CANCEL, 16'd7, 12'd0, 12'd0, 16'h0);          // silent free
      send_cmd(REQ_MOVE, 16'd9999, 12'd5, 12'd5, 16'h0);         // unknown id
      send_cmd(REQ_UP, 16'd9999, 12'd0, 12'd0, 16'h0);
      send_cmd(REQ_DOWN, 16'd8, 12'd0, 12'd0, 16'h0);
      send_cmd(REQ_MOVE, 16'd8, 12'd0, 12'd1, 16'h0);
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'hFFFF);
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'hFFFF);         // elapsed saturates
      send_cmd(REQ_CANCEL, 16'd8, 12'd0, 12'd0, 16'h0);          // acts like up
      for (int c = 5; c < 8; c++)
         send_cmd(3'(c), 16'($urandom), 12'($urandom), 12'($urandom), 16'($urandom));
   endtask

   // Fill every slot, then one more down for a new id must be dropped.
   task automatic test_table_full();
      for (int i = 0; i < NSLOT; i++)
         send_cmd(REQ_DOWN, 16'(100 + i), 12'(i * 200), 12'(4095 - i * 200), 16'h0);
      send_cmd(REQ_DOWN, 16'd500, 12'd1234, 12'd2345, 16'h0);
      send_cmd(REQ_TICK, 16'h0, 12'd0, 12'd0, 16'd300);          // sixteen taps at once
      for (int i = 0; i < NSLOT; i++)
         send_cmd(REQ_CANCEL, 16'(100 + i), 12'd0, 12'd0, 16'h0);
   endtask

   // Random traffic on a small id pool so gestures actually run to completion.
   task automatic test_random_traffic(int count, int idle_pct);
      logic [2:0]  kind;
      logic [15:0] id;
      logic [11:0] x, y;
      logic [15:0] dt;
      int          pick;
      sender_idle_pct = idle_pct;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 24)      kind = REQ_DOWN;
         else if (pick < 52) kind = REQ_MOVE;
         else if (pick < 67) kind = REQ_UP;
         else if (pick < 74) kind = REQ_CANCEL;
         else if (pick < 97) kind = REQ_TICK;
         else                kind = 3'($urandom_range(7, 5));
         id = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
         if ($urandom_range(3) == 0) begin
            x = 12'($urandom);
            y = 12'($urandom);
         end else begin
            x = 12'(2048 + $urandom_range(6) - 3);
            y = 12'(2048 + $urandom_range(6) - 3);
         end
         dt = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(120));
         send_cmd(kind, id, x, y, dt);
      end
      sender_idle_pct = 0;
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TAP_TIME;
      csr_data  = '0;
      tap_ms    = 16'd200;
      gap_ms    = 16'd200;
      speed_lim = 16'd50;
      idle_ms   = 16'd50;
      for (int i = 0; i < NSLOT; i++) begin
         tbl_kind[i] = KIND_FREE;
         tbl_id[i]   = '0;
         tbl_x[i]    = '0;
         tbl_y[i]    = '0;
         tbl_ms[i]   = '0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_gesture_paths();
      test_table_full();
      test_random_traffic(50, 0);
      set_timing(16'd0, 16'd0, 16'd0, 16'd0);
      test_random_traffic(40, 62);
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      test_random_traffic(40, 36);
      set_timing(16'($urandom_range(150, 20)), 16'($urandom_range(150, 20)),
                 16'($urandom_range(3000)), 16'($urandom_range(100)));
      test_random_traffic(60, 62);
      set_timing(16'd200, 16'd200, 16'd50, 16'd50);
      test_random_traffic(58, 0);

      drain_events();
      $display("Covered %0d commands and %0d events over five timing settings,",
               items_sent, events_seen);
      $display("including a full slot table, double taps and saturated elapsed time.");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
